// File: rtl/ddsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsr_pkg
// Types and constants shared by the differential drive speed ramp blocks.
// ----------------------------------------------------------------------------
package ddsr_pkg;

  // signed working width for speeds, offsets and sums
  typedef logic signed [17:0] ddsr_val_t;

  localparam ddsr_val_t SPEED_MAX       = 18'sd25600;
  localparam ddsr_val_t SNAP_GAP        = 18'sd2000;
  localparam ddsr_val_t LOW_ACCEL_SPEED = 18'sd7000;
  localparam ddsr_val_t LEFT_TRIM       = 18'sd750;
  localparam ddsr_val_t LEFT_MAX        = 18'sd27000;
  localparam ddsr_val_t PIVOT_EXTRA     = 18'sd2000;
  localparam logic [15:0] JUMP_ACCEL    = 16'd5000;

  localparam logic [15:0] ACCEL_STEP_RST  = 16'd2000;
  localparam logic [13:0] TURN_OFFSET_RST = 14'd2500;
  localparam logic [14:0] MIN_SPEED_RST   = 15'd7000;

  localparam logic [1:0] TURN_STRAIGHT = 2'b00;
  localparam logic [1:0] TURN_RIGHT    = 2'b01;
  localparam logic [1:0] TURN_LEFT     = 2'b11;

  typedef enum logic [1:0] {
    CFG_ACCEL_STEP  = 2'd0,
    CFG_TURN_OFFSET = 2'd1,
    CFG_MIN_SPEED   = 2'd2
  } ddsr_cfg_idx_e;

  typedef struct packed {
    logic [15:0] accel_step;
    logic [13:0] turn_offset;
    logic [14:0] min_speed;
  } ddsr_cfg_t;

  typedef struct packed {
    logic [7:0] speed_percent;
    logic       want_forward;
    logic [1:0] turn_request;
  } ddsr_item_t;

  typedef struct packed {
    logic [14:0] speed;
    logic        forward;
    logic [1:0]  turn;
  } ddsr_state_t;

  typedef struct packed {
    logic [14:0] left_duty;
    logic [14:0] right_duty;
    logic        left_forward;
    logic        right_forward;
    logic [14:0] ramped_speed;
    logic        extra_delay;
  } ddsr_result_t;

endpackage

// File: rtl/ddsr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsr_if
// Valid/ready channels for update items and wheel command items.
// ----------------------------------------------------------------------------
interface ddsr_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        speed_percent;
  logic              want_forward;
  logic signed [1:0] turn_request;

  modport source (output valid, speed_percent, want_forward, turn_request, input ready);
  modport sink (input valid, speed_percent, want_forward, turn_request, output ready);
endinterface

interface ddsr_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] left_duty;
  logic [14:0] right_duty;
  logic        left_forward;
  logic        right_forward;
  logic [14:0] ramped_speed;
  logic        extra_delay;

  modport source (output valid, left_duty, right_duty, left_forward, right_forward,
                  ramped_speed, extra_delay, input ready);
  modport sink (input valid, left_duty, right_duty, left_forward, right_forward,
                ramped_speed, extra_delay, output ready);
endinterface

// File: rtl/ddsr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsr_cfg
// Configuration registers: ramp step, turn offset and minimum speed.
// ----------------------------------------------------------------------------
module ddsr_cfg
  import ddsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output ddsr_cfg_t   cfg_o
);

  ddsr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step  <= ACCEL_STEP_RST;
      cfg_q.turn_offset <= TURN_OFFSET_RST;
      cfg_q.min_speed   <= MIN_SPEED_RST;
    end else if (cfg_we_i) begin
      case (ddsr_cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_STEP:  cfg_q.accel_step  <= cfg_wdata_i;
        CFG_TURN_OFFSET: cfg_q.turn_offset <= cfg_wdata_i[13:0];
        CFG_MIN_SPEED:   cfg_q.min_speed   <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/ddsr_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsr_calc
// Target mapping, ramp, clamp and wheel mixing for one update item.
// ----------------------------------------------------------------------------
module ddsr_calc
  import ddsr_pkg::*;
(
  input  ddsr_item_t   item_i,
  input  ddsr_state_t  state_i,
  input  ddsr_cfg_t    cfg_i,
  output ddsr_state_t  state_o,
  output ddsr_result_t res_o
);

  ddsr_val_t ms, acc, acc_q4, tr, tr2, tr_half, floor_v;
  ddsr_val_t target, cur0, diff, adiff, ramp, sum;
  ddsr_val_t inner, outer, lsp, rsp;
  logic      dir_chg, fwd_n, ldir, rdir, delay;
  logic [14:0] cur;

  assign ms      = $signed({3'b000, cfg_i.min_speed});
  assign acc     = $signed({2'b00, cfg_i.accel_step});
  assign acc_q4  = $signed({4'b0000, cfg_i.accel_step[15:2]});
  assign tr      = $signed({4'b0000, cfg_i.turn_offset});
  assign tr2     = $signed({3'b000, cfg_i.turn_offset, 1'b0});
  assign tr_half = $signed({5'b00000, cfg_i.turn_offset[13:1]});
  assign floor_v = ms + PIVOT_EXTRA;
  assign cur0    = $signed({3'b000, state_i.speed});

  // target and direction handling
  always_comb begin
    target  = $signed({2'b00, item_i.speed_percent, 8'h00});
    if (target < ms) target = '0;
    dir_chg = item_i.want_forward != state_i.forward;
    fwd_n   = state_i.forward;
    if (dir_chg) begin
      if (state_i.speed == '0) fwd_n = item_i.want_forward;
      target = '0;
    end
  end

  // ramp toward target and clamp
  always_comb begin
    diff  = target - cur0;
    adiff = (diff < 0) ? -diff : diff;
    sum   = cur0 + ((cur0 < LOW_ACCEL_SPEED) ? acc_q4 : acc);
    if (cfg_i.accel_step >= JUMP_ACCEL) begin
      ramp = target;
    end else if (adiff < SNAP_GAP) begin
      ramp = target;
    end else if (target < cur0) begin
      ramp = (cur0 < ms) ? target : cur0 - acc;
    end else if (cur0 < ms) begin
      ramp = cur0 + ms;
    end else begin
      ramp = (sum > target) ? target : sum;
    end
    if (ramp < 0) cur = '0;
    else if (ramp > SPEED_MAX) cur = SPEED_MAX[14:0];
    else cur = ramp[14:0];
  end

  // inner and outer wheel for a turn while moving
  always_comb begin
    if ($signed({3'b000, cur}) - tr < floor_v) begin
      inner = floor_v;
      outer = (floor_v + tr2 > SPEED_MAX) ? SPEED_MAX : floor_v + tr2;
    end else if ($signed({3'b000, cur}) + tr > SPEED_MAX) begin
      outer = SPEED_MAX;
      inner = (SPEED_MAX - tr2 < floor_v) ? floor_v : SPEED_MAX - tr2;
    end else begin
      inner = $signed({3'b000, cur}) - tr;
      outer = $signed({3'b000, cur}) + tr;
    end
  end

  always_comb begin
    ldir  = fwd_n;
    rdir  = fwd_n;
    lsp   = $signed({3'b000, cur});
    rsp   = $signed({3'b000, cur});
    delay = 1'b0;
    if (item_i.turn_request != state_i.turn) begin
      delay = 1'b1;
    end else if (state_i.turn == TURN_LEFT || state_i.turn == TURN_RIGHT) begin
      if (cur == '0) begin
        // pivot in place
        ldir = (state_i.turn == TURN_RIGHT);
        rdir = ~ldir;
        lsp  = floor_v + tr_half;
        rsp  = floor_v + tr_half;
      end else if (state_i.turn == TURN_LEFT) begin
        lsp = inner;
        rsp = outer;
      end else begin
        lsp = outer;
        rsp = inner;
      end
    end
    if (cur != '0) lsp = lsp + LEFT_TRIM;
    if (lsp > LEFT_MAX) lsp = LEFT_MAX;
    if (rsp > SPEED_MAX) rsp = SPEED_MAX;
  end

  assign state_o.speed   = cur;
  assign state_o.forward = fwd_n;
  assign state_o.turn    = item_i.turn_request;

  assign res_o.left_duty     = lsp[14:0];
  assign res_o.right_duty    = rsp[14:0];
  assign res_o.left_forward  = ldir;
  assign res_o.right_forward = rdir;
  assign res_o.ramped_speed  = cur;
  assign res_o.extra_delay   = delay;

endmodule

// File: rtl/differential_drive_speed_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_speed_ramp
// Speed ramp and left/right wheel mixer for a differential-drive robot.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   speed_percent, want_forward, turn_request
//   out_o    out  valid/ready   left/right duty and direction, ramped_speed,
//                               extra_delay
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless out_o stalls; out_o is driven from a result register.
// The speed/direction/turn state updates when an item leaves the input
// register, so the following item already sees it.
// A stalled out_o holds its item; the input register still takes one more.
// Reset: speed 0, forward, straight; registers at their defaults.
// ----------------------------------------------------------------------------
module differential_drive_speed_ramp
  import ddsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  ddsr_in_if.sink     in_i,
  ddsr_out_if.source  out_o
);

  ddsr_cfg_t    cfg;
  ddsr_item_t   item_q;
  logic         item_vld_q;
  ddsr_state_t  state_q, state_d;
  ddsr_result_t res_q, res_d;
  logic         res_vld_q;
  logic         advance;

  ddsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ddsr_calc u_calc (
    .item_i  (item_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign advance  = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.speed_percent <= in_i.speed_percent;
      item_q.want_forward  <= in_i.want_forward;
      item_q.turn_request  <= in_i.turn_request;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.speed   <= '0;
      state_q.forward <= 1'b1;
      state_q.turn    <= TURN_STRAIGHT;
      res_vld_q       <= 1'b0;
    end else if (advance) begin
      state_q   <= state_d;
      res_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = res_vld_q;
  assign out_o.left_duty     = res_q.left_duty;
  assign out_o.right_duty    = res_q.right_duty;
  assign out_o.left_forward  = res_q.left_forward;
  assign out_o.right_forward = res_q.right_forward;
  assign out_o.ramped_speed  = res_q.ramped_speed;
  assign out_o.extra_delay   = res_q.extra_delay;

endmodule
